### src/dss_pkg.sv
// dss_pkg: payload types, configuration types and register indexes
// for the delimiter string splitter; no dependencies
package dss_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 64;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEP_LENGTH = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEP_BYTES  = 4'd1;

   // register reset values: a single space separator
   localparam logic [3:0]  SEP_LENGTH_RESET = 4'd1;
   localparam logic [63:0] SEP_BYTES_RESET  = 64'd32;

   // token counter saturates here
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // input transfer payload
   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   // result transfer payload
   typedef struct packed {
      logic        byte_valid;
      logic [7:0]  token_byte;
      logic        token_end;
      logic        string_done;
      logic [15:0] token_total;
   } rsp_type;

   // separator settings as held by the register bank
   typedef struct packed {
      logic [3:0]  sep_length;
      logic [63:0] sep_bytes;
   } csr_type;

   // one result offered by the engine to the output register
   typedef struct packed {
      logic    emit;
      rsp_type data;
   } emit_type;

endpackage

### src/dss_in_stage.sv
// dss_in_stage: input register between the request channel and the engine
// depends on dss_pkg
module dss_in_stage import dss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    item_valid,
   output req_type item,
   input  logic    item_take
);

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   logic    load;

   // the register frees up in the same cycle the engine takes its item
   assign req_stall = valid_ff && !item_take;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (item_take || !valid_ff) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = data_ff;

endmodule

### src/dss_engine.sv
// dss_engine: lookahead window, separator compare, held token byte and
// token counter; one scan step and at most one result per cycle while
// out_ready is high; depends on dss_pkg
module dss_engine import dss_pkg::*; #(
   parameter int MAX_SEPARATOR = 8
) (
   input  logic     clock,
   input  logic     reset,
   input  csr_type  csr,
   input  logic     item_valid,
   input  req_type  item,
   output logic     item_take,
   input  logic     out_ready,
   output emit_type result
);

   localparam int FILL_W = $clog2(MAX_SEPARATOR + 1);

   typedef enum logic [4:0] {
      MODE_SCAN  = 5'b00001,
      MODE_LOOP  = 5'b00010,
      MODE_TAIL  = 5'b00100,
      MODE_CLOSE = 5'b01000,
      MODE_DONE  = 5'b10000
   } mode_type;

   mode_type          mode_ff, mode_in;
   logic [7:0]        win_ff [MAX_SEPARATOR];
   logic [7:0]        win_in [MAX_SEPARATOR];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        held_ff, held_in;
   logic              held_valid_ff, held_valid_in;
   logic [15:0]       count_ff, count_in;
   logic              last_ff, last_in;

   logic [FILL_W-1:0] len;
   logic [7:0]        base_win [MAX_SEPARATOR];
   logic [FILL_W-1:0] base_fill;
   logic [7:0]        sh1_win [MAX_SEPARATOR];
   logic [7:0]        shl_win [MAX_SEPARATOR];
   logic              match;
   logic              busy;

   // separator length in force, clamped to 1..MAX_SEPARATOR
   always_comb begin
      if (csr.sep_length == 4'd0) begin
         len = FILL_W'(1);
      end else if (int'(csr.sep_length) > MAX_SEPARATOR) begin
         len = FILL_W'(MAX_SEPARATOR);
      end else begin
         len = FILL_W'(csr.sep_length);
      end
   end

   // window as seen by this cycle's step: the new byte joins it on a scan
   always_comb begin
      for (int i = 0; i < MAX_SEPARATOR; i++) begin
         base_win[i] = win_ff[i];
         if (mode_ff == MODE_SCAN && fill_ff == FILL_W'(i)) begin
            base_win[i] = item.data_byte;
         end
      end
      base_fill = fill_ff;
      if (mode_ff == MODE_SCAN && int'(fill_ff) < MAX_SEPARATOR) begin
         base_fill = fill_ff + FILL_W'(1);
      end
   end

   // separator compare over the first len window bytes
   always_comb begin
      match = 1'b1;
      for (int j = 0; j < MAX_SEPARATOR; j++) begin
         if (FILL_W'(j) < len && base_win[j] != csr.sep_bytes[8*j +: 8]) begin
            match = 1'b0;
         end
      end
   end

   // window dropped by one byte and by a whole separator
   always_comb begin
      for (int i = 0; i < MAX_SEPARATOR; i++) begin
         sh1_win[i] = base_win[i];
         shl_win[i] = base_win[i];
         if (i + 1 < MAX_SEPARATOR) begin
            sh1_win[i] = base_win[i+1];
         end
         for (int k = 1; k < MAX_SEPARATOR - i; k++) begin
            if (len == FILL_W'(k)) begin
               shl_win[i] = base_win[i+k];
            end
         end
      end
   end

   // one step of the scan
   always_comb begin
      mode_in       = mode_ff;
      win_in        = win_ff;
      fill_in       = fill_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      result        = '0;
      busy          = 1'b0;

      case (mode_ff)
         MODE_SCAN, MODE_LOOP: begin
            busy    = (mode_ff == MODE_LOOP) || item_valid;
            last_in = (mode_ff == MODE_SCAN) ? item.final_byte : last_ff;
            win_in  = base_win;
            fill_in = base_fill;
            if (base_fill >= len) begin
               if (match) begin
                  // separator found: drop it and close the open token
                  win_in  = shl_win;
                  fill_in = base_fill - len;
                  if (held_valid_ff) begin
                     result.emit            = 1'b1;
                     result.data.byte_valid = 1'b1;
                     result.data.token_byte = held_ff;
                     result.data.token_end  = 1'b1;
                     if (count_ff != COUNT_MAX) begin
                        count_in = count_ff + 16'd1;
                     end
                     held_valid_in = 1'b0;
                  end
               end else begin
                  // oldest byte joins the token, the held one goes out
                  win_in        = sh1_win;
                  fill_in       = base_fill - FILL_W'(1);
                  result.emit   = held_valid_ff;
                  result.data.byte_valid = 1'b1;
                  result.data.token_byte = held_ff;
                  held_in       = base_win[0];
                  held_valid_in = 1'b1;
               end
            end
            if (fill_in >= len) begin
               mode_in = MODE_LOOP;
            end else if (last_in) begin
               mode_in = (fill_in != '0) ? MODE_TAIL : MODE_CLOSE;
            end else begin
               mode_in = MODE_SCAN;
            end
         end
         MODE_TAIL: begin
            // short tail: leftover window bytes join the token
            busy          = 1'b1;
            win_in        = sh1_win;
            fill_in       = fill_ff - FILL_W'(1);
            result.emit   = held_valid_ff;
            result.data.byte_valid = 1'b1;
            result.data.token_byte = held_ff;
            held_in       = win_ff[0];
            held_valid_in = 1'b1;
            if (fill_ff == FILL_W'(1)) begin
               mode_in = MODE_CLOSE;
            end
         end
         MODE_CLOSE: begin
            busy = 1'b1;
            if (held_valid_ff) begin
               result.emit            = 1'b1;
               result.data.byte_valid = 1'b1;
               result.data.token_byte = held_ff;
               result.data.token_end  = 1'b1;
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 16'd1;
               end
               held_valid_in = 1'b0;
            end
            mode_in = MODE_DONE;
         end
         MODE_DONE: begin
            // done result, then back to an empty string
            busy                    = 1'b1;
            result.emit             = 1'b1;
            result.data.string_done = 1'b1;
            result.data.token_total = count_ff;
            count_in                = '0;
            fill_in                 = '0;
            held_valid_in           = 1'b0;
            last_in                 = 1'b0;
            mode_in                 = MODE_SCAN;
         end
         default: begin
            mode_in = MODE_SCAN;
         end
      endcase

      // nothing moves unless a step runs and the output register can take a result
      if (!out_ready || !busy) begin
         result.emit = 1'b0;
      end
   end

   assign item_take = out_ready && (mode_ff == MODE_SCAN) && item_valid;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_SCAN;
         fill_ff       <= '0;
         held_valid_ff <= 1'b0;
         count_ff      <= '0;
         last_ff       <= 1'b0;
      end else if (out_ready && busy) begin
         mode_ff       <= mode_in;
         fill_ff       <= fill_in;
         held_valid_ff <= held_valid_in;
         count_ff      <= count_in;
         last_ff       <= last_in;
      end
   end

   // window and held byte payload
   always_ff @(posedge clock) begin
      if (out_ready && busy) begin
         win_ff  <= win_in;
         held_ff <= held_in;
      end
   end

endmodule

### src/dss_out_stage.sv
// dss_out_stage: result register between the engine and the result channel
// depends on dss_pkg
module dss_out_stage import dss_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  emit_type result,
   output logic     out_ready,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // a new result may enter while the held one leaves
   assign out_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (out_ready) begin
         valid_in = result.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && result.emit) begin
         data_ff <= result.data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

### src/delimiter_string_splitter_core.sv
// delimiter_string_splitter_core: top level of the multi-byte separator
// tokenizer; depends on dss_pkg, dss_in_stage, dss_engine, dss_out_stage
//
//   port group   direction   carries
//   req_*        in          one string byte and its last-byte mark
//   rsp_*        out         one token byte with end mark, or the done count
//   csr_*        in          separator length (index 0) and bytes (index 1)
//
// Items with at most one result, such as plain bytes, stream at one per
// cycle while rsp_stall is low, through the input and output registers.
// The engine emits one result per cycle while the output register takes
// it; later items wait. A string's last byte runs its scan steps, a tail
// step per leftover byte, then close and done. Reset empties the window
// and sets the separator to a single space. A stalled result holds the
// output register and engine; the input register fills, req_stall rises.
module delimiter_string_splitter_core import dss_pkg::*; #(
   parameter int MAX_SEPARATOR = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   csr_type  csr_ff;
   csr_type  csr_in;
   logic     item_valid;
   req_type  item;
   logic     item_take;
   logic     out_ready;
   emit_type result;

   // register bank, writes to unknown indexes are dropped
   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SEP_LENGTH: csr_in.sep_length = csr_wdata[3:0];
            CSR_SEP_BYTES:  csr_in.sep_bytes  = csr_wdata;
            default:        csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.sep_length <= SEP_LENGTH_RESET;
         csr_ff.sep_bytes  <= SEP_BYTES_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   dss_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   dss_engine #(
      .MAX_SEPARATOR (MAX_SEPARATOR)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .out_ready  (out_ready),
      .result     (result)
   );

   dss_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### sim/delimiter_string_splitter_core_test.sv
// delimiter_string_splitter_core_test: self-checking bench for the separator
// tokenizer, with its own token predictor; depends on dss_pkg and the core RTL
module delimiter_string_splitter_core_test;
   import dss_pkg::*;

   localparam int SEP_SLOTS     = 8;
   localparam int CYCLE_LIMIT   = 3000000;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int REPORT_LIMIT  = 10;
   localparam int PHASE_COUNT   = 10;

   // one queued string byte and whether it waits for all results first
   typedef struct packed {
      req_type data;
      logic    hold_for_drain;
   } pending_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // predictor copy of the separator settings and the scan state
   logic [3:0]  sep_length = SEP_LENGTH_RESET;
   logic [63:0] sep_bytes  = SEP_BYTES_RESET;
   logic [7:0]  window_q [SEP_SLOTS] = '{default: 8'd0};
   int unsigned window_fill = 0;
   logic [7:0]  held_byte   = 8'd0;
   logic        held_valid  = 1'b0;
   logic [15:0] token_count = 16'd0;

   pending_type pending_bytes[$];
   rsp_type     expected_tokens[$];

   int          send_idle_pct   = 0;
   int          recv_stall_pct  = 0;
   int          fail_count      = 0;
   int          queued_count    = 0;
   int          bytes_sent      = 0;
   int          results_checked = 0;
   int          strings_done    = 0;
   int          settings_used   = 0;
   int unsigned cycle_count     = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   delimiter_string_splitter_core #(
      .MAX_SEPARATOR(SEP_SLOTS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // separator length in force: zero acts as one, oversize is clamped
   function automatic int unsigned active_length();
      if (sep_length == 4'd0) return 1;
      if (sep_length > SEP_SLOTS) return SEP_SLOTS;
      return sep_length;
   endfunction

   // drop k bytes from the front of the lookahead window
   task automatic shift_window(input int unsigned k);
      if (k >= window_fill) begin
         window_fill = 0;
      end else begin
         for (int unsigned j = 0; j + k < window_fill; j++) window_q[j] = window_q[j + k];
         window_fill -= k;
      end
   endtask

   // the previously held byte goes out, the new one is held back
   task automatic append_token_byte(input logic [7:0] value);
      if (held_valid) expected_tokens.push_back(rsp_type'{1'b1, held_byte, 1'b0, 1'b0, 16'd0});
      held_byte  = value;
      held_valid = 1'b1;
   endtask

   // held byte goes out with the end mark; empty tokens send nothing
   task automatic close_token();
      if (held_valid) begin
         expected_tokens.push_back(rsp_type'{1'b1, held_byte, 1'b1, 1'b0, 16'd0});
         if (token_count != COUNT_MAX) token_count++;
         held_valid = 1'b0;
      end
   endtask

   // predict the results caused by one accepted string byte
   task automatic split_byte(input req_type item);
      int unsigned len;
      logic        hit;
      len = active_length();
      if (window_fill < SEP_SLOTS) begin
         window_q[window_fill] = item.data_byte;
         window_fill++;
      end
      // rescan until the window is shorter than the separator
      while (window_fill >= len) begin
         hit = 1'b1;
         for (int unsigned j = 0; j < len; j++)
            if (window_q[j] != sep_bytes[8*j +: 8]) hit = 1'b0;
         if (hit) begin
            shift_window(len);
            close_token();
         end else begin
            append_token_byte(window_q[0]);
            shift_window(1);
         end
      end
      // short tail joins the token, then the done count
      if (item.final_byte) begin
         for (int unsigned j = 0; j < window_fill; j++) append_token_byte(window_q[j]);
         window_fill = 0;
         close_token();
         expected_tokens.push_back(rsp_type'{1'b0, 8'd0, 1'b0, 1'b1, token_count});
         window_q    = '{default: 8'd0};
         held_byte   = 8'd0;
         held_valid  = 1'b0;
         token_count = 16'd0;
         strings_done++;
      end
   endtask

   // register write; the predictor follows once the write edge has passed
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (index == CSR_SEP_LENGTH) sep_length = value[3:0];
      else if (index == CSR_SEP_BYTES) sep_bytes = value;
   endtask

   // wait for every byte to be sent and every result back, then settle
   task automatic wait_drained();
      int waited;
      waited = 0;
      while (bytes_sent != queued_count) @(negedge clock);
      while (expected_tokens.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_byte(input logic [7:0] value, input logic last, input logic hold);
      pending_bytes.push_back(pending_type'{req_type'{value, last}, hold});
      queued_count++;
   endtask

   task automatic queue_text(input string text, input logic close_it);
      for (int i = 0; i < text.len(); i++)
         queue_byte(text[i], close_it && i == text.len() - 1, 1'b0);
   endtask

   // leading bytes of the separator in force; a full one when count is the length
   task automatic add_separator(ref logic [7:0] text[$], input int unsigned count);
      for (int unsigned j = 0; j < count; j++) text.push_back(sep_bytes[8*j +: 8]);
   endtask

   // token content leans on separator bytes so that partial matches are common
   function automatic logic [7:0] pick_text_byte();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 40) return sep_bytes[8*$urandom_range(active_length() - 1) +: 8];
      if (roll < 60) return 8'($urandom);
      return 8'("a" + $urandom_range(3));
   endfunction

   // mostly well-formed token strings, some noise and broken separators
   task automatic queue_random_string(input logic close_it);
      logic [7:0]  text[$];
      int unsigned len;
      int unsigned n_tokens;
      len = active_length();
      if ($urandom_range(99) < 20) begin
         repeat ($urandom_range(1, 12)) text.push_back(8'($urandom));
      end else begin
         n_tokens = $urandom_range(1, 4);
         if ($urandom_range(3) == 0) add_separator(text, len);
         for (int t = 0; t < n_tokens; t++) begin
            repeat ($urandom_range(0, 4)) text.push_back(pick_text_byte());
            if (t + 1 < n_tokens) begin
               if ($urandom_range(99) < 15) begin
                  add_separator(text, $urandom_range(len - 1));
                  text.push_back(pick_text_byte());
               end else begin
                  add_separator(text, len);
                  if ($urandom_range(3) == 0) add_separator(text, len);
               end
            end
         end
         if ($urandom_range(3) == 0) add_separator(text, len);
      end
      if (text.size() == 0) text.push_back(pick_text_byte());
      foreach (text[i])
         queue_byte(text[i], close_it && i == text.size() - 1,
                    i == 0 && $urandom_range(19) == 0);
   endtask

   // input driver: predicts each transfer, then offers the next byte
   always @(posedge clock) begin : byte_driver
      logic launch;
      launch = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_stall) begin
         // stalled transfer keeps its payload
      end else begin
         if (req_valid) begin
            split_byte(req_data);
            bytes_sent++;
         end
         if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct &&
             !(pending_bytes[0].hold_for_drain && expected_tokens.size() != 0)) begin
            req_data <= pending_bytes[0].data;
            void'(pending_bytes.pop_front());
            launch = 1'b1;
         end
         req_valid <= launch;
      end
   end

   // result monitor: each transfer against the oldest expectation
   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (expected_tokens.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("unexpected result: valid %0b byte %02h end %0b done %0b total %0d",
                           rsp_data.byte_valid, rsp_data.token_byte, rsp_data.token_end,
                           rsp_data.string_done, rsp_data.token_total);
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_data.byte_valid !== want.byte_valid ||
                   rsp_data.token_byte !== want.token_byte ||
                   rsp_data.token_end !== want.token_end ||
                   rsp_data.string_done !== want.string_done ||
                   rsp_data.token_total !== want.token_total) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("mismatch: expected valid %0b byte %02h end %0b done %0b total %0d, %s",
                              want.byte_valid, want.token_byte, want.token_end,
                              want.string_done, want.token_total,
                              $sformatf("got valid %0b byte %02h end %0b done %0b total %0d",
                                        rsp_data.byte_valid, rsp_data.token_byte,
                                        rsp_data.token_end, rsp_data.string_done,
                                        rsp_data.token_total));
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   initial begin : stimulus
      logic [63:0] sep_word;
      logic [63:0] length_word;
      logic [7:0]  pat_a;
      logic [7:0]  pat_b;
      logic [3:0]  phase_len;
      int          phase_start;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      settings_used = 1;

      // reset separator: leading, doubled and trailing spaces
      queue_text(" ab  c ", 1'b1);
      queue_byte(8'hFF, 1'b1, 1'b0);
      // separator only, sent once every result is back: zero tokens
      queue_byte(" ", 1'b1, 1'b1);
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b1, 1'b0);
      wait_drained();

      // three byte separator holding a zero byte, junk above its length
      write_csr(CSR_SEP_BYTES, 64'hDEAD_BEEF_F078_0078);
      write_csr(CSR_SEP_LENGTH, 64'hFFFF_FFFF_FFFF_FFF3);
      settings_used++;
      // match up front, then a short tail joins the token
      queue_byte("x", 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte("x", 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte("x", 1'b1, 1'b0);
      // string left open while the length shrinks
      queue_byte("a", 1'b0, 1'b0);
      queue_byte("x", 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      wait_drained();
      write_csr(4'd2, '1);
      write_csr(4'd15, 64'h0123_4567_89AB_CDEF);
      write_csr(CSR_SEP_LENGTH, 64'd1);
      settings_used++;
      queue_byte("b", 1'b0, 1'b0);
      queue_byte("q", 1'b1, 1'b0);
      wait_drained();

      // random phases: lengths at the extremes first, odd phases but the last end mid-string
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: phase_len = 4'd1;
            1: phase_len = 4'd8;
            2: phase_len = 4'd0;
            3: phase_len = 4'd15;
            default: phase_len = 4'($urandom_range(15));
         endcase
         if ($urandom_range(1) == 0) begin
            sep_word = {$urandom, $urandom};
         end else begin
            pat_a = $urandom;
            pat_b = ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom);
            for (int j = 0; j < SEP_SLOTS; j++)
               sep_word[8*j +: 8] = $urandom_range(1) ? pat_a : pat_b;
         end
         length_word      = {$urandom, $urandom};
         length_word[3:0] = phase_len;
         write_csr(CSR_SEP_BYTES, sep_word);
         write_csr(CSR_SEP_LENGTH, length_word);
         if (p % 3 == 1) write_csr(4'($urandom_range(2, 15)), {$urandom, $urandom});
         settings_used++;
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         phase_start = queued_count;
         while (queued_count - phase_start < 8) queue_random_string(1'b1);
         queue_random_string(p % 2 == 0 || p == PHASE_COUNT - 1);
         wait_drained();
      end

      if (expected_tokens.size() != 0) begin
         $display("%0d expected results never arrived", expected_tokens.size());
         fail_count += expected_tokens.size();
      end
      $display("sent %0d bytes in %0d strings under %0d separator settings",
               bytes_sent, strings_done, settings_used);
      $display("checked %0d results across idle and stall mixes", results_checked);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### filelist.f
src/dss_pkg.sv
src/dss_in_stage.sv
src/dss_engine.sv
src/dss_out_stage.sv
src/delimiter_string_splitter_core.sv
sim/delimiter_string_splitter_core_test.sv
